// File: design/lfu_cache_replacement_defines.svh
// Assertion macros for the LFU cache replacement block
`ifndef LFU_CACHE_REPLACEMENT_DEFINES_SVH
`define LFU_CACHE_REPLACEMENT_DEFINES_SVH
// Check that an antecedent implies a consequent in the next cycle
`define LFU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
// Check that an antecedent implies a consequent in the same cycle
`define LFU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`endif

// File: design/lfu_pkg.sv
// Package with shared constants and types for the LFU cache replacement block
package lfu_pkg;
    localparam int DefaultEntries = 16;
    localparam int KeyWidth       = 31;
    localparam int ValueWidth     = 31;
    localparam int CountWidth     = 32;
    localparam int CapWidth       = 5;
    localparam logic [CapWidth-1:0] CapReset = 5'd16;
    localparam logic ActGet = 1'b0;
    localparam logic ActPut = 1'b1;
    typedef logic [KeyWidth-1:0]   key_t;
    typedef logic [ValueWidth-1:0] value_t;
    typedef logic [CountWidth-1:0] count_t;
endpackage

// File: design/lfu_cache_replacement.sv
// Top level of the LFU cache replacement block with LRU tie-break
// An item is taken when start is high and busy is low. The block works through
// the stored entries one per cycle out of the entry memory: a scan over all
// ENTRIES entries finds a key match, the victim and the free slot, then one
// update pass over all entries rewrites ranks and the touched entry. Each pass
// reads every entry in turn, folds in the last read data and then leaves the
// pass; a decide state lies between the two passes and a done state follows
// the second. Busy stays high through both sweeps over the entry memory, so a
// new item is taken only once the last one is done. The result appears on hit,
// read_value, evicted and evicted_key for one cycle with done high; it cannot
// be held off. Configuration writes (cfg_we, cfg_data) are taken at any time
// and must come only while idle.
`include "lfu_cache_replacement_defines.svh"
module lfu_cache_replacement #(
    parameter int ENTRIES = lfu_pkg::DefaultEntries
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            action,
    input  logic [lfu_pkg::KeyWidth-1:0]    lookup_key,
    input  logic [lfu_pkg::ValueWidth-1:0]  write_value,
    input  logic                            cfg_we,
    input  logic [lfu_pkg::CapWidth-1:0]    cfg_data,
    output logic                            done,
    output logic                            hit,
    output logic [lfu_pkg::ValueWidth-1:0]  read_value,
    output logic                            evicted,
    output logic [lfu_pkg::KeyWidth-1:0]    evicted_key
);
    import lfu_pkg::*;

    localparam int IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CntW = $clog2(ENTRIES + 1);
    localparam int RankW = IdxW;
    localparam int CmpW = (CntW > CapWidth) ? CntW : CapWidth;
    localparam logic [CntW-1:0] EntriesC = CntW'(ENTRIES);

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StScan = 3'd1;
    localparam logic [2:0] StDecide = 3'd2;
    localparam logic [2:0] StUpd = 3'd3;
    localparam logic [2:0] StDone = 3'd4;

    typedef struct packed {
        key_t               key;
        value_t             value;
        count_t             count;
        logic [RankW-1:0]   rank;
    } entry_t;

    // Entry memory and per-entry valid bits
    entry_t mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg, valid_next;

    logic [2:0]           state_reg, state_next;
    logic [CapWidth-1:0]  cap_reg;
    logic [CntW-1:0]      occ_reg, occ_next;
    logic [IdxW:0]        ptr_reg, ptr_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic [IdxW-1:0]      rd_idx_reg, rd_idx_next;
    entry_t               rd_data_reg;

    logic                 act_reg;
    key_t                 key_reg;
    value_t               val_reg;

    logic                 found_reg, found_next;
    logic [IdxW-1:0]      fidx_reg, fidx_next;
    entry_t               fent_reg, fent_next;
    logic                 vic_reg, vic_next;
    logic [IdxW-1:0]      vidx_reg, vidx_next;
    entry_t               vent_reg, vent_next;
    logic                 free_reg, free_next;
    logic [IdxW-1:0]      slot_reg, slot_next;

    // Decisions made after the scan
    logic                 do_evict_reg, do_evict_next;
    logic                 do_ins_reg, do_ins_next;
    logic [IdxW-1:0]      tgt_reg, tgt_next;
    logic [RankW-1:0]     oldr_reg, oldr_next;
    logic [RankW-1:0]     evr_reg, evr_next;

    logic                 res_hit_reg, res_ev_reg;
    value_t               res_rd_reg;
    key_t                 res_evk_reg;

    logic                 mem_we;
    logic [IdxW-1:0]      mem_wa;
    entry_t               mem_wd;
    logic                 mem_re;
    logic [IdxW-1:0]      mem_ra;

    logic [CntW-1:0]      eff_lim;
    logic                 rd_v;

    // Clamp the capacity limit to 1..ENTRIES
    always_comb
    begin
        if (cap_reg == '0)
            eff_lim = CntW'(1);
        else if (CmpW'(cap_reg) > CmpW'(ENTRIES))
            eff_lim = EntriesC;
        else
            eff_lim = CntW'(cap_reg);
    end

    // Memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (mem_re)
            rd_data_reg <= mem[mem_ra];
    end

    assign rd_v = rd_vld_reg && valid_reg[rd_idx_reg];

    // Control and scan logic
    always_comb
    begin
        state_next = state_reg;
        ptr_next = ptr_reg;
        rd_vld_next = 1'b0;
        rd_idx_next = rd_idx_reg;
        found_next = found_reg;
        fidx_next = fidx_reg;
        fent_next = fent_reg;
        vic_next = vic_reg;
        vidx_next = vidx_reg;
        vent_next = vent_reg;
        free_next = free_reg;
        slot_next = slot_reg;
        do_evict_next = do_evict_reg;
        do_ins_next = do_ins_reg;
        tgt_next = tgt_reg;
        oldr_next = oldr_reg;
        evr_next = evr_reg;
        valid_next = valid_reg;
        occ_next = occ_reg;
        mem_we = 1'b0;
        mem_wa = rd_idx_reg;
        mem_wd = rd_data_reg;
        mem_re = 1'b0;
        mem_ra = ptr_reg[IdxW-1:0];

        unique case (state_reg)
            StIdle:
            begin
                if (start)
                begin
                    state_next = StScan;
                    ptr_next = '0;
                    found_next = 1'b0;
                    vic_next = 1'b0;
                    free_next = 1'b0;
                end
            end
            StScan:
            begin
                // Issue one read per cycle, then fold in the returned entry
                if (ptr_reg < (IdxW+1)'(ENTRIES))
                begin
                    mem_re = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = ptr_reg[IdxW-1:0];
                    ptr_next = ptr_reg + 1'b1;
                end
                if (rd_vld_reg)
                begin
                    if (!valid_reg[rd_idx_reg])
                    begin
                        if (!free_reg)
                        begin
                            free_next = 1'b1;
                            slot_next = rd_idx_reg;
                        end
                    end
                    else
                    begin
                        if (!found_reg && rd_data_reg.key == key_reg)
                        begin
                            found_next = 1'b1;
                            fidx_next = rd_idx_reg;
                            fent_next = rd_data_reg;
                        end
                        if (!vic_reg || rd_data_reg.count < vent_reg.count ||
                            (rd_data_reg.count == vent_reg.count &&
                             rd_data_reg.rank > vent_reg.rank))
                        begin
                            vic_next = 1'b1;
                            vidx_next = rd_idx_reg;
                            vent_next = rd_data_reg;
                        end
                    end
                end
                else if (ptr_reg == (IdxW+1)'(ENTRIES))
                    state_next = StDecide;
            end
            StDecide:
            begin
                do_evict_next = 1'b0;
                do_ins_next = 1'b0;
                tgt_next = fidx_reg;
                oldr_next = fent_reg.rank;
                evr_next = vent_reg.rank;
                if (!found_reg && act_reg == ActPut)
                begin
                    if (occ_reg >= eff_lim && vic_reg)
                    begin
                        do_evict_next = 1'b1;
                        do_ins_next = 1'b1;
                        tgt_next = free_reg ? slot_reg : vidx_reg;
                        // Lowest free index after freeing the victim
                        if (free_reg && slot_reg < vidx_reg)
                            tgt_next = slot_reg;
                        else
                            tgt_next = vidx_reg;
                        valid_next[vidx_reg] = 1'b0;
                        occ_next = occ_reg - 1'b1;
                    end
                    else if (free_reg)
                    begin
                        do_ins_next = 1'b1;
                        tgt_next = slot_reg;
                    end
                end
                ptr_next = '0;
                state_next = StUpd;
            end
            StUpd:
            begin
                // Read each entry, adjust its rank, write it back
                if (ptr_reg < (IdxW+1)'(ENTRIES))
                begin
                    mem_re = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = ptr_reg[IdxW-1:0];
                    ptr_next = ptr_reg + 1'b1;
                end
                if (rd_vld_reg)
                begin
                    mem_wa = rd_idx_reg;
                    mem_wd = rd_data_reg;
                    if (do_ins_reg && rd_idx_reg == tgt_reg)
                    begin
                        mem_we = 1'b1;
                        mem_wd.key = key_reg;
                        mem_wd.value = val_reg;
                        mem_wd.count = count_t'(1);
                        mem_wd.rank = '0;
                        valid_next[rd_idx_reg] = 1'b1;
                        occ_next = occ_reg + 1'b1;
                    end
                    else if (found_reg && rd_idx_reg == tgt_reg)
                    begin
                        mem_we = 1'b1;
                        mem_wd.rank = '0;
                        if (act_reg == ActPut)
                            mem_wd.value = val_reg;
                        if (rd_data_reg.count != '1)
                            mem_wd.count = rd_data_reg.count + 1'b1;
                    end
                    else if (rd_v)
                    begin
                        mem_we = 1'b1;
                        if (found_reg)
                        begin
                            if (rd_data_reg.rank < oldr_reg)
                                mem_wd.rank = rd_data_reg.rank + 1'b1;
                        end
                        else if (do_ins_reg)
                        begin
                            if (do_evict_reg && rd_data_reg.rank > evr_reg)
                                mem_wd.rank = rd_data_reg.rank;
                            else
                                mem_wd.rank = rd_data_reg.rank + 1'b1;
                        end
                    end
                end
                else if (ptr_reg == (IdxW+1)'(ENTRIES))
                    state_next = StDone;
            end
            StDone:
                state_next = StIdle;
            default:
                state_next = StIdle;
        endcase
    end

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= StIdle;
            cap_reg <= CapReset;
            valid_reg <= '0;
            occ_reg <= '0;
            ptr_reg <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                cap_reg <= cfg_data;
            valid_reg <= valid_next;
            occ_reg <= occ_next;
            ptr_reg <= ptr_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
        found_reg <= found_next;
        fidx_reg <= fidx_next;
        fent_reg <= fent_next;
        vic_reg <= vic_next;
        vidx_reg <= vidx_next;
        vent_reg <= vent_next;
        free_reg <= free_next;
        slot_reg <= slot_next;
        do_evict_reg <= do_evict_next;
        do_ins_reg <= do_ins_next;
        tgt_reg <= tgt_next;
        oldr_reg <= oldr_next;
        evr_reg <= evr_next;
        if (state_reg == StIdle && start)
        begin
            act_reg <= action;
            key_reg <= lookup_key;
            val_reg <= write_value;
        end
        if (state_reg == StDecide)
        begin
            res_hit_reg <= found_reg;
            res_rd_reg <= (found_reg && act_reg == ActGet) ? fent_reg.value : '0;
            res_ev_reg <= do_evict_next;
            res_evk_reg <= do_evict_next ? vent_reg.key : '0;
        end
    end

    assign busy = (state_reg != StIdle);
    assign done = (state_reg == StDone);
    assign hit = done ? res_hit_reg : 1'b0;
    assign read_value = done ? res_rd_reg : '0;
    assign evicted = done ? res_ev_reg : 1'b0;
    assign evicted_key = done ? res_evk_reg : '0;

    // Checks
    `LFU_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done, "done held two cycles")
    `LFU_ASSERT_NOW(a_occ_bound, clk, rst_n, 1'b1, occ_reg <= EntriesC, "occupancy over size")
    `LFU_ASSERT_NOW(a_occ_valid, clk, rst_n, state_reg == StIdle,
        occ_reg == CntW'($countones(valid_reg)), "occupancy differs from valid bits")
    `LFU_ASSERT_NOW(a_evict_hit, clk, rst_n, done, !(hit && evicted), "evicted on a hit")
endmodule
